[rtl/laser_range_frame_parser_defines.svh]
// Assertion helpers, clocked on clk, quiet while rst_n is low.
`ifndef LASER_RANGE_FRAME_PARSER_DEFINES_SVH
`define LASER_RANGE_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define LRFP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrfp assertion failed");

// Next-cycle implication.
`define LRFP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrfp assertion failed");

`endif

[rtl/lrfp_pkg.sv]
package lrfp_pkg;

    localparam logic [15:0] GAP_LIMIT_RESET = 16'd80;
    localparam logic [15:0] GAP_MAX         = 16'hFFFF;
    localparam logic [7:0]  HEADER_BYTE     = 8'hAA;
    localparam logic [7:0]  LEN_HI_BYTE     = 8'h00;
    localparam logic [7:0]  LEN_LO_BYTE     = 8'h04;
    localparam logic [7:0]  FUNC_FIRST      = 8'h20;
    localparam logic [7:0]  FUNC_LAST       = 8'h22;

    localparam logic [3:0]  POS_HEADER      = 4'd0;
    localparam logic [3:0]  POS_FUNC        = 4'd3;
    localparam logic [3:0]  POS_LEN_HI      = 4'd4;
    localparam logic [3:0]  POS_LEN_LO      = 4'd5;
    localparam logic [3:0]  POS_BCD_FIRST   = 4'd6;
    localparam logic [3:0]  POS_BCD_LAST    = 4'd9;
    localparam logic [3:0]  POS_CHECKSUM    = 4'd12;

    localparam logic        KIND_BYTE       = 1'b0;
    localparam logic        KIND_TICK       = 1'b1;

    localparam int          QUEUE_DEPTH     = 2;
    localparam int          BCD_PAIRS       = 4;
    localparam int          DIST_W          = 28;

    typedef struct packed {
        logic [31:0] bcd;
        logic [1:0]  code;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_CONV = 3'b010,
        B_DONE = 3'b100
    } back_state_t;

endpackage

[rtl/lrfp_if.sv]
interface lrfp_rx_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface lrfp_res_if;
    logic        valid;
    logic        ready;
    logic [27:0] distance_mm;
    logic [1:0]  function_code;
    modport source (output valid, output distance_mm, output function_code, input ready);
    modport sink (input valid, input distance_mm, input function_code, output ready);
endinterface

interface lrfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/lrfp_front.sv]
module lrfp_front (
    input  logic              clk,
    input  logic              rst_n,
    lrfp_rx_if.sink           rx,
    lrfp_cfg_if.sink          cfg,
    input  lrfp_pkg::q_stat_t q_stat,
    output logic              push,
    output lrfp_pkg::frame_t  push_data
);

    logic [15:0] gap_limit_reg;
    logic [15:0] gap_reg, gap_next, gap_inc;
    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] bcd_reg, bcd_next;
    logic [1:0]  code_reg, code_next;
    logic        func_ok_reg, func_ok_next;
    logic        len_hi_ok_reg, len_hi_ok_next;
    logic        len_lo_ok_reg, len_lo_ok_next;
    logic        take;

    assign rx.ready  = !q_stat.full;
    assign cfg.ready = 1'b1;
    assign take      = rx.valid && rx.ready;
    assign gap_inc   = (gap_reg == lrfp_pkg::GAP_MAX) ? gap_reg : gap_reg + 16'd1;

    assign push_data.bcd  = bcd_reg;
    assign push_data.code = code_reg;

    always_comb
    begin
        gap_next       = gap_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        bcd_next       = bcd_reg;
        code_next      = code_reg;
        func_ok_next   = func_ok_reg;
        len_hi_ok_next = len_hi_ok_reg;
        len_lo_ok_next = len_lo_ok_reg;
        push           = 1'b0;
        if (take)
        begin
            if (rx.kind == lrfp_pkg::KIND_TICK)
            begin
                gap_next = gap_inc;
                if (pos_reg != lrfp_pkg::POS_HEADER && gap_inc > gap_limit_reg)
                begin
                    pos_next = lrfp_pkg::POS_HEADER;
                end
            end
            else if (!(pos_reg == lrfp_pkg::POS_HEADER && rx.rx_byte != lrfp_pkg::HEADER_BYTE))
            begin
                gap_next = '0;
                if (pos_reg != lrfp_pkg::POS_CHECKSUM)
                begin
                    pos_next = pos_reg + 4'd1;
                    sum_next = (pos_reg == lrfp_pkg::POS_HEADER) ? 8'd0 : sum_reg + rx.rx_byte;
                    if (pos_reg == lrfp_pkg::POS_FUNC)
                    begin
                        func_ok_next = rx.rx_byte >= lrfp_pkg::FUNC_FIRST
                                    && rx.rx_byte <= lrfp_pkg::FUNC_LAST;
                        code_next    = rx.rx_byte[1:0];
                    end
                    if (pos_reg == lrfp_pkg::POS_LEN_HI)
                    begin
                        len_hi_ok_next = rx.rx_byte == lrfp_pkg::LEN_HI_BYTE;
                    end
                    if (pos_reg == lrfp_pkg::POS_LEN_LO)
                    begin
                        len_lo_ok_next = rx.rx_byte == lrfp_pkg::LEN_LO_BYTE;
                    end
                    if (pos_reg >= lrfp_pkg::POS_BCD_FIRST && pos_reg <= lrfp_pkg::POS_BCD_LAST)
                    begin
                        bcd_next = {bcd_reg[23:0], rx.rx_byte};
                    end
                end
                else
                begin
                    pos_next = lrfp_pkg::POS_HEADER;
                    push     = len_hi_ok_reg && len_lo_ok_reg && func_ok_reg
                            && sum_reg == rx.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg <= lrfp_pkg::GAP_LIMIT_RESET;
            gap_reg       <= '0;
            pos_reg       <= lrfp_pkg::POS_HEADER;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                gap_limit_reg <= cfg.data;
            end
            gap_reg <= gap_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        bcd_reg       <= bcd_next;
        code_reg      <= code_next;
        func_ok_reg   <= func_ok_next;
        len_hi_ok_reg <= len_hi_ok_next;
        len_lo_ok_reg <= len_lo_ok_next;
    end

endmodule

[rtl/lrfp_queue.sv]
module lrfp_queue #(
    parameter int Depth = lrfp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lrfp_pkg::frame_t  push_data,
    input  logic              pop,
    output lrfp_pkg::frame_t  pop_data,
    output lrfp_pkg::q_stat_t stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

    lrfp_pkg::frame_t entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign stat.full  = count_reg == DepthCnt;
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/lrfp_back.sv]
module lrfp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lrfp_pkg::q_stat_t q_stat,
    input  lrfp_pkg::frame_t  pop_data,
    output logic              pop,
    output logic              busy,
    lrfp_res_if.source        res
);

    localparam int StepW = $clog2(lrfp_pkg::BCD_PAIRS);
    localparam logic [StepW-1:0] LastStep = StepW'(lrfp_pkg::BCD_PAIRS - 1);
    localparam int DW = lrfp_pkg::DIST_W;

    lrfp_pkg::back_state_t state_reg, state_next;
    logic [StepW-1:0]  step_reg, step_next;
    logic [31:0]       bcd_reg, bcd_next;
    logic [1:0]        code_reg, code_next;
    logic [DW-1:0]     acc_reg, acc_next;
    logic [DW-1:0]     pair;
    logic [DW-1:0]     dist_out_reg;
    logic [1:0]        code_out_reg;
    logic              out_valid_reg, out_valid_next;
    logic              load;

    // hi*10 + lo, nibbles taken at face value
    assign pair = DW'({bcd_reg[31:28], 3'b000}) + DW'({bcd_reg[31:28], 1'b0})
                + DW'(bcd_reg[27:24]);

    assign pop  = state_reg == lrfp_pkg::B_IDLE && !q_stat.empty;
    assign busy = state_reg != lrfp_pkg::B_IDLE;
    assign load = state_reg == lrfp_pkg::B_DONE && (!out_valid_reg || res.ready);

    assign res.valid         = out_valid_reg;
    assign res.distance_mm   = dist_out_reg;
    assign res.function_code = code_out_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        bcd_next       = bcd_reg;
        code_next      = code_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            lrfp_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    bcd_next   = pop_data.bcd;
                    code_next  = pop_data.code;
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = lrfp_pkg::B_CONV;
                end
            end
            lrfp_pkg::B_CONV:
            begin
                // acc*100 = acc*64 + acc*32 + acc*4
                acc_next  = (acc_reg << 6) + (acc_reg << 5) + (acc_reg << 2) + pair;
                bcd_next  = {bcd_reg[23:0], 8'h00};
                step_next = step_reg + StepW'(1);
                if (step_reg == LastStep)
                begin
                    state_next = lrfp_pkg::B_DONE;
                end
            end
            lrfp_pkg::B_DONE:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = lrfp_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = lrfp_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrfp_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        bcd_reg  <= bcd_next;
        code_reg <= code_next;
        acc_reg  <= acc_next;
        if (load)
        begin
            dist_out_reg <= acc_reg;
            code_out_reg <= code_reg;
        end
    end

endmodule

[rtl/laser_range_frame_parser.sv]
// Range-frame parser.
// rx: one transfer per received UART byte (kind 0) or per 1 ms tick (kind 1).
// cfg: one transfer writes gap_limit_ticks; always ready.
// res: one transfer per good frame, carrying distance_mm and function_code.
// The front takes one rx transfer per cycle while the frame queue has room; it
// tracks position, running checksum and the four BCD bytes as bytes arrive.
// A good frame enters the queue on the transfer of its checksum byte.
// The back converts the BCD bytes, one pair per cycle, and loads the output
// register once the last pair is in; it takes a new frame from the queue only
// when idle, while frames arrive at most one per 13 bytes.
// A stalled res channel holds its result; the queue absorbs further frames and
// rx.ready drops only once the queue is full.
// Reset clears position, gap count, queue and output valid, and sets
// gap_limit_ticks to 80; no clearing pass is needed.
module laser_range_frame_parser #(
    parameter int QueueDepth = lrfp_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    lrfp_rx_if.sink     rx,
    lrfp_cfg_if.sink    cfg,
    lrfp_res_if.source  res
);

`include "laser_range_frame_parser_defines.svh"

    lrfp_pkg::q_stat_t q_stat;
    lrfp_pkg::frame_t  push_data, pop_data;
    logic              push, pop, back_busy;

    lrfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    lrfp_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    lrfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .busy     (back_busy),
        .res      (res)
    );

    `LRFP_ASSERT_IMP(a_no_push_when_full, push, !q_stat.full)
    `LRFP_ASSERT_IMP(a_code_range, res.valid, res.function_code != 2'd3)
    `LRFP_ASSERT_NXT(a_pop_starts_back, pop, back_busy)

endmodule
